/* hdl/tqjb_pkg.sv */
// ----------------------------------------------------------------------------
// tqjb_pkg
// Shared types and codes of the three-column join buffer.
// ----------------------------------------------------------------------------
package tqjb_pkg;

	localparam int NUM_COLS      = 3;
	localparam int COL_SEL_BITS  = 2;
	localparam int LIMIT_BITS    = 5;
	localparam int COUNT_BITS    = 14;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 14;
	localparam int OUT_BITS      = 32;
	localparam int STATUS_BITS   = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 14'h3FFF;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_COLUMN_LIMIT = 1'b0,
		CFG_ITEM_QUOTA   = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic push;
		logic pop;
	} col_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} col_stat_t;

endpackage

/* hdl/tqjb_cell.sv */
// ----------------------------------------------------------------------------
// tqjb_cell
// One storage cell of a column: load a new item or take the upper neighbour's.
// ----------------------------------------------------------------------------
module tqjb_cell #(
	parameter int ITEM_BITS = 32
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic signed [ITEM_BITS-1:0] load_data,
	input  logic                        shift,
	input  logic signed [ITEM_BITS-1:0] next_data,
	output logic signed [ITEM_BITS-1:0] data_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

endmodule

/* hdl/tqjb_column.sv */
// ----------------------------------------------------------------------------
// tqjb_column
// One FIFO column built as a row of cells with a fill counter.
// ----------------------------------------------------------------------------
module tqjb_column
	import tqjb_pkg::*;
#(
	parameter int COLUMN_DEPTH = 16,
	parameter int ITEM_BITS    = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  col_ctrl_t                   ctrl,
	input  logic signed [ITEM_BITS-1:0] item_in,
	input  logic [LIMIT_BITS-1:0]       limit,
	output logic signed [ITEM_BITS-1:0] head,
	output col_stat_t                   stat
);

	localparam int FILL_BITS = $clog2(COLUMN_DEPTH + 1);
	localparam int CMP_BITS  = (FILL_BITS > LIMIT_BITS) ? FILL_BITS : LIMIT_BITS;

	logic [FILL_BITS-1:0]        fill_q;
	logic signed [ITEM_BITS-1:0] cell_data [COLUMN_DEPTH];

	for (genvar i = 0; i < COLUMN_DEPTH; i++) begin : g_cell
		logic signed [ITEM_BITS-1:0] next_data;
		if (i < COLUMN_DEPTH - 1) begin : g_mid
			assign next_data = cell_data[i+1];
		end else begin : g_last
			assign next_data = cell_data[i];
		end
		tqjb_cell #(
			.ITEM_BITS(ITEM_BITS)
		) u_cell (
			.clk      (clk),
			.load     (ctrl.push && (fill_q == FILL_BITS'(i))),
			.load_data(item_in),
			.shift    (ctrl.pop),
			.next_data(next_data),
			.data_q   (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.push) begin
			fill_q <= fill_q + FILL_BITS'(1);
		end else if (ctrl.pop) begin
			fill_q <= fill_q - FILL_BITS'(1);
		end
	end

	always_comb begin
		stat.empty = (fill_q == '0);
		stat.full  = (fill_q >= FILL_BITS'(COLUMN_DEPTH)) ||
		             (CMP_BITS'(fill_q) >= CMP_BITS'(limit));
	end

	assign head = cell_data[0];

endmodule

/* hdl/three_queue_join_buffer_unit.sv */
// ----------------------------------------------------------------------------
// three_queue_join_buffer_unit
// Three FIFO columns joined on pop, with one limit for every column and an item quota.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | action, column, item_value
//  out     | out_valid/out_ready| status, head_zero, head_one, head_two,
//          |                    | remaining
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle unless the output stalls: an item is applied to the
//  columns when accepted; its result is in the output register next cycle.
//  The input is ready whenever the output register is empty or being taken.
//  A stalled output holds its result and blocks the input; cfg is always ready.
//  Reset empties all columns, clears the pushed count and loads the registers.
// ----------------------------------------------------------------------------
module three_queue_join_buffer_unit
	import tqjb_pkg::*;
#(
	parameter int COLUMN_DEPTH = 16,
	parameter int ITEM_BITS    = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [COL_SEL_BITS-1:0]        column,
	input  logic signed [OUT_BITS-1:0]     item_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [STATUS_BITS-1:0]         status,
	output logic signed [OUT_BITS-1:0]     head_zero,
	output logic signed [OUT_BITS-1:0]     head_one,
	output logic signed [OUT_BITS-1:0]     head_two,
	output logic [COUNT_BITS-1:0]          remaining,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]       cfg_data
);

	logic [LIMIT_BITS-1:0]       limit_q;
	logic [COUNT_BITS-1:0]       quota_q;
	logic [COUNT_BITS-1:0]       added_q;
	logic [COUNT_BITS-1:0]       added_next;
	logic                        out_valid_q;
	status_t                     status_q;
	logic signed [OUT_BITS-1:0]  head_q [NUM_COLS];
	logic [COUNT_BITS-1:0]       remaining_q;

	col_ctrl_t                   ctrl [NUM_COLS];
	col_stat_t                   stat [NUM_COLS];
	logic signed [ITEM_BITS-1:0] head [NUM_COLS];
	logic signed [ITEM_BITS-1:0] item_narrow;

	logic    accept;
	logic    sel_full;
	logic    push_ok;
	logic    pop_ok;
	status_t status_next;

	assign cfg_ready   = 1'b1;
	assign in_ready    = !out_valid_q || out_ready;
	assign accept      = in_valid && in_ready;
	assign item_narrow = ITEM_BITS'(item_value);

	always_comb begin
		case (column)
			2'd0:    sel_full = stat[0].full;
			2'd1:    sel_full = stat[1].full;
			2'd2:    sel_full = stat[2].full;
			default: sel_full = 1'b1;
		endcase
	end

	always_comb begin
		push_ok     = accept && (action == ACT_PUSH) && !sel_full;
		pop_ok      = accept && (action == ACT_POP) &&
		              !stat[0].empty && !stat[1].empty && !stat[2].empty;
		status_next = ST_DONE;
		if (action == ACT_PUSH) begin
			if (sel_full) begin
				status_next = ST_FULL;
			end
		end else if (!pop_ok) begin
			status_next = ST_EMPTY;
		end
		added_next = added_q;
		if (push_ok && (added_q != COUNT_MAX)) begin
			added_next = added_q + COUNT_BITS'(1);
		end
	end

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
		always_comb begin
			ctrl[c].push = push_ok && (column == COL_SEL_BITS'(c));
			ctrl[c].pop  = pop_ok;
		end
		tqjb_column #(
			.COLUMN_DEPTH(COLUMN_DEPTH),
			.ITEM_BITS   (ITEM_BITS)
		) u_column (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl[c]),
			.item_in(item_narrow),
			.limit  (limit_q),
			.head   (head[c]),
			.stat   (stat[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			quota_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COLUMN_LIMIT: limit_q <= cfg_data[LIMIT_BITS-1:0];
				CFG_ITEM_QUOTA:   quota_q <= cfg_data[COUNT_BITS-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			added_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			added_q <= added_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_next;
			remaining_q <= (quota_q > added_next) ? (quota_q - added_next) : '0;
			for (int c = 0; c < NUM_COLS; c++) begin
				head_q[c] <= pop_ok ? OUT_BITS'(head[c]) : '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign head_zero = head_q[0];
	assign head_one  = head_q[1];
	assign head_two  = head_q[2];
	assign remaining = remaining_q;

endmodule

/* hdl/tqjb_checker.sv */
// ----------------------------------------------------------------------------
// tqjb_checker
// Port-level checks of the join buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tqjb_checker
	import tqjb_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [STATUS_BITS-1:0]     status,
	input logic signed [OUT_BITS-1:0] head_zero,
	input logic signed [OUT_BITS-1:0] head_one,
	input logic signed [OUT_BITS-1:0] head_two,
	input logic [COUNT_BITS-1:0]      remaining
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(head_zero) && $stable(remaining))
		else $error("stalled result changed");

	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while result stalled");

	a_heads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DONE) |->
		(head_zero == '0) && (head_one == '0) && (head_two == '0))
		else $error("refused item carries heads");

endmodule

bind three_queue_join_buffer_unit tqjb_checker u_tqjb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status   (status),
	.head_zero(head_zero),
	.head_one (head_one),
	.head_two (head_two),
	.remaining(remaining)
);

/* verif/three_queue_join_buffer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_queue_join_buffer_unit_tb
// Self-checking bench for the three-column join buffer. A shadow of the
// columns, the fill limit and the quota count predicts each result row. The
// bench runs a short directed sequence and then random phases under changing
// register settings, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module three_queue_join_buffer_unit_tb;
	import tqjb_pkg::*;

	localparam int          COLUMN_DEPTH = 16;
	localparam int          PHASES       = 10;
	localparam int          PHASE_ITEMS  = 190;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          SHOWN_ERRORS = 10;
	localparam logic [1:0]  COL_NONE     = 2'd3;

	typedef struct {
		status_t               status;
		logic [OUT_BITS-1:0]   heads [NUM_COLS];
		logic [COUNT_BITS-1:0] remaining;
	} join_row_t;

	class join_buffer_shadow;
		logic [OUT_BITS-1:0] held [NUM_COLS][$];
		int unsigned         col_limit;
		int unsigned         quota;
		int unsigned         pushed;
		join_row_t           awaited[$];
		int unsigned         failures;

		function new();
			col_limit = LIMIT_RESET;
			quota     = 0;
			pushed    = 0;
			failures  = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == CFG_COLUMN_LIMIT)
				col_limit = data[LIMIT_BITS-1:0];
			else
				quota = data[COUNT_BITS-1:0];
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_item(action_t act, logic [COL_SEL_BITS-1:0] col,
				logic [OUT_BITS-1:0] value);
			join_row_t   row;
			int unsigned cap;
			row.status    = ST_DONE;
			row.heads     = '{default: '0};
			cap = (col_limit > COLUMN_DEPTH) ? COLUMN_DEPTH : col_limit;
			if (act == ACT_PUSH) begin
				if (col >= NUM_COLS || held[col].size() >= cap) begin
					row.status = ST_FULL;
				end else begin
					held[col].push_back(value);
					if (pushed < COUNT_MAX)
						pushed++;
				end
			end else if (held[0].size() == 0 || held[1].size() == 0 || held[2].size() == 0) begin
				row.status = ST_EMPTY;
			end else begin
				for (int c = 0; c < NUM_COLS; c++)
					row.heads[c] = held[c].pop_front();
			end
			row.remaining = (quota > pushed) ? COUNT_BITS'(quota - pushed) : '0;
			awaited.push_back(row);
		endfunction

		function void check_result(join_row_t got);
			join_row_t want;
			bit        bad;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= SHOWN_ERRORS)
					$display("result with no item pending: status %0d", got.status);
				return;
			end
			want = awaited.pop_front();
			bad  = (got.status !== want.status) || (got.remaining !== want.remaining);
			for (int c = 0; c < NUM_COLS; c++)
				bad |= (got.heads[c] !== want.heads[c]);
			if (bad) begin
				failures++;
				if (failures <= SHOWN_ERRORS)
					$display("mismatch: expected st %0d heads %h %h %h rem %0d, got st %0d heads %h %h %h rem %0d",
						want.status, want.heads[0], want.heads[1], want.heads[2],
						want.remaining, got.status, got.heads[0], got.heads[1],
						got.heads[2], got.remaining);
			end
		endfunction
	endclass

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic                         action     = ACT_PUSH;
	logic [COL_SEL_BITS-1:0]      column     = '0;
	logic signed [OUT_BITS-1:0]   item_value = '0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [STATUS_BITS-1:0]       status;
	logic signed [OUT_BITS-1:0]   head_zero;
	logic signed [OUT_BITS-1:0]   head_one;
	logic signed [OUT_BITS-1:0]   head_two;
	logic [COUNT_BITS-1:0]        remaining;
	logic                         cfg_valid  = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_BITS-1:0]      cfg_index  = '0;
	logic [CFG_DATA_BITS-1:0]     cfg_data   = '0;

	join_buffer_shadow shadow = new();
	bit                idling = 1'b1;
	int unsigned       stall_left = 0;
	int unsigned       cycle_count = 0;

	three_queue_join_buffer_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.column     (column),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.head_zero  (head_zero),
		.head_one   (head_one),
		.head_two   (head_two),
		.remaining  (remaining),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pause_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		join_row_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status    = status_t'(status);
			got.heads[0]  = head_zero;
			got.heads[1]  = head_one;
			got.heads[2]  = head_two;
			got.remaining = remaining;
			shadow.check_result(got);
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idling && $urandom_range(0, 3) == 0) begin
			stall_left = pause_length() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(action_t act, logic [COL_SEL_BITS-1:0] col,
			logic [OUT_BITS-1:0] value);
		int unsigned gap;
		gap = (idling && $urandom_range(0, 99) >= 55) ? pause_length() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		column     <= col;
		item_value <= value;
		do @(posedge clk); while (!in_ready);
		shadow.note_item(act, col, value);
	endtask

	// hold the input back until every result row has been taken
	task automatic settle();
		in_valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_registers(logic [CFG_DATA_BITS-1:0] limit_data,
			logic [CFG_DATA_BITS-1:0] quota_data);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_COLUMN_LIMIT;
		cfg_data  <= limit_data;
		do @(posedge clk); while (!cfg_ready);
		shadow.write_reg(CFG_COLUMN_LIMIT, limit_data);
		cfg_index <= CFG_ITEM_QUOTA;
		cfg_data  <= quota_data;
		do @(posedge clk); while (!cfg_ready);
		shadow.write_reg(CFG_ITEM_QUOTA, quota_data);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(int unsigned push_pct);
		action_t                 act;
		logic [COL_SEL_BITS-1:0] col;
		logic [OUT_BITS-1:0]     value;
		act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
		col = ($urandom_range(0, 99) < 4) ? COL_NONE : COL_SEL_BITS'($urandom_range(0, 2));
		case ($urandom_range(0, 9))
			0: value = 32'h8000_0000;
			1: value = 32'h7FFF_FFFF;
			2: value = '1;
			3: value = '0;
			default: value = $urandom;
		endcase
		send_item(act, col, value);
	endtask

	task automatic directed_items();
		send_item(ACT_POP, 2'd0, 32'h0);
		send_item(ACT_PUSH, COL_NONE, 32'h1234_5678);
		send_item(ACT_PUSH, 2'd0, 32'h7FFF_FFFF);
		send_item(ACT_PUSH, 2'd1, 32'h8000_0000);
		send_item(ACT_PUSH, 2'd2, 32'hFFFF_FFFF);
		send_item(ACT_POP, COL_NONE, 32'hFFFF_FFFF);
		send_item(ACT_POP, 2'd0, 32'h0);
		send_item(ACT_PUSH, 2'd0, 32'h0);
		send_item(ACT_PUSH, 2'd1, 32'hAAAA_AAAA);
		send_item(ACT_POP, 2'd1, 32'h0);
		send_item(ACT_PUSH, 2'd2, 32'h5555_5555);
		send_item(ACT_POP, 2'd2, 32'h0);
		settle();
		// zero limit refuses every push
		set_registers(14'd0, 14'd5);
		send_item(ACT_PUSH, 2'd0, 32'h1);
		send_item(ACT_PUSH, 2'd2, 32'h2);
		send_item(ACT_POP, 2'd0, 32'h0);
		settle();
		// upper data bits fall outside the limit register
		set_registers(14'h3FE1, 14'd3);
		send_item(ACT_PUSH, 2'd0, 32'h11);
		send_item(ACT_PUSH, 2'd0, 32'h22);
		send_item(ACT_PUSH, 2'd1, 32'h33);
		send_item(ACT_PUSH, 2'd2, 32'h44);
		send_item(ACT_PUSH, 2'd1, 32'h55);
		send_item(ACT_POP, 2'd0, 32'h0);
		send_item(ACT_PUSH, 2'd0, 32'h66);
		send_item(ACT_PUSH, 2'd1, 32'h77);
		settle();
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned limits [PHASES];
		int unsigned quotas [PHASES];
		limits = '{16, 31, 1, 0, 8, 5, 3, 16, 2, 12};
		quotas = '{16383, 500, 0, 2000, 77, 100, 16383, 1234, 40, 9000};
		limits[5] = $urandom_range(1, 16);
		quotas[4] = $urandom_range(0, 16383);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		for (int p = 0; p < PHASES; p++) begin
			set_registers(CFG_DATA_BITS'(limits[p]), CFG_DATA_BITS'(quotas[p]));
			idling = !(p == 3 || p == 7);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 1 && i == PHASE_ITEMS / 2)
					settle();
				random_item((p % 2 != 0) ? 45 : 72);
			end
			settle();
		end
		idling = 1'b1;
		if (shadow.failures == 0 && shadow.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
